/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low
`define LCI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low
`define LCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define LCI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LCI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/lci_pkg.sv */
// Shared constants and types of the level crossing interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package lci_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int IDX_BITS      = 12;
  localparam int COUNT_BITS    = 7;
  localparam int MAX_RECORDED  = 64;
  localparam int FRAC_BITS     = 16;
  localparam int DIV_STEP_BITS = $clog2(FRAC_BITS);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [IDX_BITS-1:0] ROW_LAST = {IDX_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CROSSINGS = 2'd1;

  // Result kinds
  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration seen by the front end
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] threshold;
    logic [COUNT_BITS-1:0]         max_crossings;
  } lci_cfg_t;

  // Work handed from front end to back end
  typedef struct packed {
    logic                  ev_valid;
    logic                  ev_crossing;
    logic [IDX_BITS-1:0]   ev_index;
    logic [FRAC_BITS-1:0]  ev_num;
    logic [FRAC_BITS-1:0]  ev_den;
    logic [COUNT_BITS-1:0] ev_count;
    logic                  ev_ovf;
    logic                  sum_valid;
    logic [COUNT_BITS-1:0] sum_count;
    logic                  sum_ovf;
  } lci_cmd_t;

endpackage

`default_nettype wire

/* rtl/lci_front.sv */
// Front end: row state, crossing detection, count limit and command build.
// Depends on lci_pkg.
`default_nettype none

module lci_front
  import lci_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lci_cfg_t                      cfg,
  input  wire logic                          take,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          row_end,
  output logic                               cmd_push,
  output lci_cmd_t                           cmd
);

  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic [IDX_BITS-1:0]           pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic                          ovf_r, ovf_nxt;

  logic signed [SAMPLE_BITS:0]   d_ta, d_ba;
  logic [FRAC_BITS-1:0]          mag_ta, mag_ba;
  logic                          crossing, touch, event_hit, record;
  logic [COUNT_BITS-1:0]         limit, cnt_upd;
  logic                          ovf_upd;

  // Pair classification
  always_comb begin
    d_ta = {cfg.threshold[SAMPLE_BITS-1], cfg.threshold} - {prev_r[SAMPLE_BITS-1], prev_r};
    d_ba = {sample[SAMPLE_BITS-1], sample} - {prev_r[SAMPLE_BITS-1], prev_r};
    mag_ta = d_ta[SAMPLE_BITS] ? FRAC_BITS'(-d_ta) : FRAC_BITS'(d_ta);
    mag_ba = d_ba[SAMPLE_BITS] ? FRAC_BITS'(-d_ba) : FRAC_BITS'(d_ba);
    crossing = have_prev_r &&
               (((prev_r > cfg.threshold) && (sample < cfg.threshold)) ||
                ((prev_r < cfg.threshold) && (sample > cfg.threshold)));
    touch = have_prev_r && (prev_r == cfg.threshold);
    event_hit = crossing || touch;
    limit = (cfg.max_crossings > COUNT_BITS'(MAX_RECORDED)) ?
            COUNT_BITS'(MAX_RECORDED) : cfg.max_crossings;
    record = event_hit && (cnt_r < limit);
  end

  // Row state update
  always_comb begin
    cnt_upd = record ? cnt_r + 1'b1 : cnt_r;
    ovf_upd = ovf_r || (event_hit && !record);
    prev_nxt = prev_r;
    have_prev_nxt = have_prev_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (take) begin
      if (row_end) begin
        prev_nxt = '0;
        have_prev_nxt = 1'b0;
        pos_nxt = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        prev_nxt = sample;
        have_prev_nxt = 1'b1;
        cnt_nxt = cnt_upd;
        ovf_nxt = ovf_upd;
        if (!have_prev_r) begin
          pos_nxt = '0;
        end else if (pos_r != ROW_LAST) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  // Command to the back end
  always_comb begin
    cmd.ev_valid    = record;
    cmd.ev_crossing = crossing;
    cmd.ev_index    = pos_r;
    cmd.ev_num      = mag_ta;
    cmd.ev_den      = mag_ba;
    cmd.ev_count    = cnt_upd;
    cmd.ev_ovf      = ovf_r;
    cmd.sum_valid   = row_end;
    cmd.sum_count   = cnt_upd;
    cmd.sum_ovf     = ovf_upd;
    cmd_push        = take && (record || row_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_prev_r <= 1'b0;
      pos_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/lci_queue.sv */
// Short command queue between front end and back end.
// Depends on lci_pkg.
`default_nettype none

module lci_queue
  import lci_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire lci_cmd_t push_cmd,
  input  wire logic     pop,
  output logic          full,
  output logic          empty,
  output lci_cmd_t      head
);

  lci_cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/lci_back.sv */
// Back end: radix-2 fraction divider, result sequencing and output register.
// Depends on lci_pkg.
`default_nettype none

module lci_back
  import lci_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire lci_cmd_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_pop,
  output logic               out_kind,
  output logic [IDX_BITS-1:0]   out_sample_index,
  output logic [FRAC_BITS-1:0]  out_fraction,
  output logic [COUNT_BITS-1:0] out_crossing_count,
  output logic                  out_overflow
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  lci_cmd_t                 cur_r, cur_nxt;
  logic [FRAC_BITS-1:0]     rem_r, rem_nxt;
  logic [FRAC_BITS-1:0]     quo_r, quo_nxt;
  logic [DIV_STEP_BITS-1:0] step_r, step_nxt;

  logic                     val_r, val_nxt;
  logic                     kind_r, kind_nxt;
  logic [IDX_BITS-1:0]      idx_r, idx_nxt;
  logic [FRAC_BITS-1:0]     frac_r, frac_nxt;
  logic [COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;

  logic [FRAC_BITS:0]       rem_sh, rem_sub;
  logic                     rem_ge, slot_free;

  assign slot_free = !val_r || out_pop;

  // One quotient bit per cycle; remainder stays below the divisor
  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    rem_sub = rem_sh - {1'b0, cur_r.ev_den};
    rem_ge  = (rem_sh >= {1'b0, cur_r.ev_den});
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    val_nxt   = val_r && !out_pop;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          rem_nxt = q_head.ev_num;
          quo_nxt = '0;
          step_nxt = '0;
          if (q_head.ev_valid && q_head.ev_crossing) begin
            state_nxt = ST_DIV;
          end else if (q_head.ev_valid) begin
            state_nxt = ST_EV;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[FRAC_BITS-1:0] : rem_sh[FRAC_BITS-1:0];
        quo_nxt  = {quo_r[FRAC_BITS-2:0], rem_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_STEP_BITS'(FRAC_BITS - 1)) begin
          state_nxt = ST_EV;
        end
      end
      ST_EV: begin
        if (slot_free) begin
          val_nxt  = 1'b1;
          kind_nxt = KIND_EVENT;
          idx_nxt  = cur_r.ev_index;
          frac_nxt = cur_r.ev_crossing ? quo_r : '0;
          cnt_nxt  = cur_r.ev_count;
          ovf_nxt  = cur_r.ev_ovf;
          state_nxt = cur_r.sum_valid ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          val_nxt  = 1'b1;
          kind_nxt = KIND_SUMMARY;
          idx_nxt  = '0;
          frac_nxt = '0;
          cnt_nxt  = cur_r.sum_count;
          ovf_nxt  = cur_r.sum_ovf;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      val_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      val_r   <= val_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid          = val_r;
  assign out_kind           = kind_r;
  assign out_sample_index   = idx_r;
  assign out_fraction       = frac_r;
  assign out_crossing_count = cnt_r;
  assign out_overflow       = ovf_r;

endmodule

`default_nettype wire

/* rtl/level_crossing_interpolator_unit.sv */
// Top level of the level crossing interpolator: config registers and wiring.
// Depends on lci_pkg, lci_front, lci_queue, lci_back and assert_macros.svh.
`default_nettype none

// Samples enter at one per cycle while the four-entry command queue has room;
// the front end classifies each adjacent pair and keeps the row position and
// crossing count. The back end works through the queue one command at a time:
// a strict crossing runs the shift-subtract fraction divider (one quotient
// bit per cycle) and then loads the output register, while a touch or a
// summary loads it directly; a new command is taken only in the idle state,
// and loading waits while an unread result holds the register. Input runs at
// one sample per cycle on rows with few crossings, else at the back end's pace.
// A row summary (kind 1) follows its row's last event. Configuration writes
// are always ready and should only be issued while the block is idle.

`include "assert_macros.svh"

module level_crossing_interpolator_unit
  import lci_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // sample input
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_row_end,
  // results
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_kind,
  output logic [IDX_BITS-1:0]                out_sample_index,
  output logic [FRAC_BITS-1:0]               out_fraction,
  output logic [COUNT_BITS-1:0]              out_crossing_count,
  output logic                               out_overflow,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

  lci_cfg_t cfg_r, cfg_nxt;
  lci_cmd_t f_cmd, q_head;
  logic     f_push, q_full, q_empty, q_pop, take, out_valid;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:     cfg_nxt.threshold = $signed(cfg_data[SAMPLE_BITS-1:0]);
        REG_MAX_CROSSINGS: cfg_nxt.max_crossings = cfg_data[COUNT_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= '0;
      cfg_r.max_crossings <= COUNT_BITS'(MAX_RECORDED);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input transfer
  assign in_full = q_full;
  assign take    = in_push && !q_full;

  lci_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .take     (take),
    .sample   (in_sample),
    .row_end  (in_row_end),
    .cmd_push (f_push),
    .cmd      (f_cmd)
  );

  lci_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_cmd (f_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  lci_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_sample_index   (out_sample_index),
    .out_fraction       (out_fraction),
    .out_crossing_count (out_crossing_count),
    .out_overflow       (out_overflow)
  );

  assign out_empty = !out_valid;

  // Checks
  `LCI_ASSERT_IMPLY(a_sum_fields, clk, rst_n, !out_empty && (out_kind == KIND_SUMMARY), (out_sample_index == '0) && (out_fraction == '0))
  `LCI_ASSERT_IMPLY(a_event_count, clk, rst_n, !out_empty && (out_kind == KIND_EVENT), out_crossing_count != '0)
  `LCI_ASSERT_IMPLY(a_count_limit, clk, rst_n, !out_empty, out_crossing_count <= COUNT_BITS'(MAX_RECORDED))
  `LCI_ASSERT_NEXT(a_queue_drain, clk, rst_n, q_pop && !f_push, !q_full)

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for level_crossing_interpolator_unit: streams sample rows, predicts the
// crossing and summary reports in the bench and checks every report popped from the block.
// Depends on lci_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb
  import lci_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic                  kind;
    logic [IDX_BITS-1:0]   sample_index;
    logic [FRAC_BITS-1:0]  fraction;
    logic [COUNT_BITS-1:0] crossing_count;
    logic                  overflow;
  } crossing_report_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          in_row_end = 1'b0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic                          out_kind;
  logic [IDX_BITS-1:0]           out_sample_index;
  logic [FRAC_BITS-1:0]          out_fraction;
  logic [COUNT_BITS-1:0]         out_crossing_count;
  logic                          out_overflow;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

  // Bench copy of the block's registers and row state
  logic signed [SAMPLE_BITS-1:0] thr_setting = '0;
  logic [COUNT_BITS-1:0]         limit_setting = COUNT_BITS'(64);
  logic signed [SAMPLE_BITS-1:0] row_prev = '0;
  logic                          row_have_prev = 1'b0;
  logic [IDX_BITS-1:0]           row_pos = '0;
  logic [COUNT_BITS-1:0]         row_count = '0;
  logic                          row_ovf = 1'b0;

  crossing_report_t expected_reports[$];

  int  errors = 0;
  int  samples_sent = 0;
  int  reports_checked = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  int  pop_hold = 0;
  bit  gaps_on = 1'b1;

  level_crossing_interpolator_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_sample          (in_sample),
    .in_row_end         (in_row_end),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_sample_index   (out_sample_index),
    .out_fraction       (out_fraction),
    .out_crossing_count (out_crossing_count),
    .out_overflow       (out_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Row tracker: one accepted sample in, zero to two expected reports queued
  function automatic void predict_reports(logic signed [SAMPLE_BITS-1:0] smp, logic last);
    longint           a, t, b;
    longint unsigned  num, den;
    logic [FRAC_BITS-1:0] frac;
    logic             hit;
    logic [COUNT_BITS-1:0] lim;
    crossing_report_t rep;
    b    = smp;
    hit  = 1'b0;
    frac = '0;
    lim  = (limit_setting < MAX_RECORDED) ? limit_setting : COUNT_BITS'(MAX_RECORDED);
    if (row_have_prev) begin
      a = row_prev;
      t = thr_setting;
      if ((a > t && b < t) || (a < t && b > t)) begin
        num  = (a < t) ? longint'(t - a) : longint'(a - t);
        den  = (a < b) ? longint'(b - a) : longint'(a - b);
        frac = FRAC_BITS'((num << FRAC_BITS) / den);
        hit  = 1'b1;
      end else if (a == t) begin
        hit = 1'b1;
      end
      if (hit) begin
        if (row_count < lim) begin
          row_count++;
          rep = '{KIND_EVENT, row_pos, frac, row_count, row_ovf};
          expected_reports.push_back(rep);
        end else begin
          row_ovf = 1'b1;
        end
      end
      if (row_pos != ROW_LAST) row_pos++;
    end else begin
      row_pos = '0;
    end
    row_prev      = smp;
    row_have_prev = 1'b1;
    if (last) begin
      rep = '{KIND_SUMMARY, '0, '0, row_count, row_ovf};
      expected_reports.push_back(rep);
      row_prev      = '0;
      row_have_prev = 1'b0;
      row_pos       = '0;
      row_count     = '0;
      row_ovf       = 1'b0;
    end
  endfunction

  // Compare one popped report against the oldest expectation
  function automatic void check_report();
    crossing_report_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected report: kind %0d index %0d fraction %0d count %0d overflow %0d",
             out_kind, out_sample_index, out_fraction, out_crossing_count, out_overflow);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (out_kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, out_kind);
      errors++;
    end
    if (out_sample_index !== want.sample_index) begin
      $error("sample_index: expected %0d, got %0d", want.sample_index, out_sample_index);
      errors++;
    end
    if (out_fraction !== want.fraction) begin
      $error("fraction: expected %0d, got %0d", want.fraction, out_fraction);
      errors++;
    end
    if (out_crossing_count !== want.crossing_count) begin
      $error("crossing_count: expected %0d, got %0d", want.crossing_count,
             out_crossing_count);
      errors++;
    end
    if (out_overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
      errors++;
    end
  endfunction

  // Result side: check each transfer, then stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_report();
        pop_hold = pick_gap();
      end
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // One sample transfer; the caller follows it with another push or a drain
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_sample  <= smp;
    in_row_end <= last;
    do @(posedge clk); while (in_full);
    predict_reports(smp, last);
    samples_sent++;
  endtask

  // Stop pushing, wait for all reports, then let the back end settle
  task automatic drain_reports();
    in_push <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers in back-to-back transfers; only called with the block idle
  task automatic set_config(input logic signed [SAMPLE_BITS-1:0] thr,
                            input logic [COUNT_BITS-1:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_DATA_BITS'(thr);
    do @(posedge clk); while (!cfg_ready);
    thr_setting = thr;
    cfg_index <= REG_MAX_CROSSINGS;
    cfg_data  <= CFG_DATA_BITS'(lim);
    do @(posedge clk); while (!cfg_ready);
    limit_setting = lim;
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  // Sample near the threshold; spread 0 means anywhere in range
  function automatic logic signed [SAMPLE_BITS-1:0] make_sample(int spread);
    longint v;
    if ($urandom_range(0, 99) < 12) return thr_setting;
    if (spread == 0) return SAMPLE_BITS'($urandom);
    v = longint'(thr_setting) + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_BITS'(v);
  endfunction

  // Crossings both ways, touches, extreme samples and thresholds, short rows
  task automatic test_directed_pairs();
    set_config(16'sd0, 7'd64);
    push_sample(-16'sd5, 1'b0);
    push_sample(16'sd10, 1'b0);
    push_sample(16'sd0, 1'b0);      // lands on threshold: no strict crossing
    push_sample(16'sd0, 1'b0);      // touch
    push_sample(-16'sd1, 1'b0);     // touch
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0); // widest span
    push_sample(16'sd0, 1'b1);      // last sample on threshold is never a touch
    push_sample(16'sd0, 1'b1);      // single-sample row
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b1); // full-range falling pair
    drain_reports();
    set_config(16'sd32767, 7'd64);
    push_sample(16'sd32767, 1'b0);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd5, 1'b1);
    drain_reports();
    set_config(-16'sd32768, 7'd64);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(-16'sd32768, 1'b1);
    drain_reports();
  endtask

  // Zero limit, a limit of one and a row that saturates the full count
  task automatic test_crossing_limit();
    int i;
    set_config(16'sd0, 7'd0);
    for (i = 0; i < 5; i++) push_sample((i % 2) ? -16'sd100 : 16'sd100, i == 4);
    drain_reports();
    set_config(16'sd0, 7'd1);
    for (i = 0; i < 4; i++) push_sample((i % 2) ? -16'sd7 : 16'sd9, i == 3);
    drain_reports();
    set_config(16'sd0, 7'd64);
    for (i = 0; i < 70; i++) push_sample((i % 2) ? -16'sd300 : 16'sd200, i == 69);
    drain_reports();
  endtask

  // Random rows of mostly short length around the current threshold
  task automatic run_random_rows(input int n_items);
    int left, len, spread, i;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 16);
      if (len > left) len = left;
      case ($urandom_range(0, 3))
        0: spread = 3;
        1: spread = 200;
        2: spread = 5000;
        default: spread = 0;
      endcase
      for (i = 0; i < len; i++) push_sample(make_sample(spread), i == len - 1);
      left -= len;
    end
  endtask

  // Several register settings, extremes among them, one phase without gaps
  task automatic test_random_traffic();
    set_config(SAMPLE_BITS'($urandom), 7'd64);
    run_random_rows(100);
    drain_reports();
    set_config(16'sd0, 7'd3);
    run_random_rows(100);
    drain_reports();
    set_config(-16'sd32768, 7'd64);
    run_random_rows(100);
    drain_reports();
    set_config(16'sd32767, 7'd0);
    run_random_rows(100);
    drain_reports();
    set_config(SAMPLE_BITS'($urandom), COUNT_BITS'($urandom_range(0, 64)));
    run_random_rows(100);
    drain_reports();
    gaps_on = 1'b0;
    set_config(SAMPLE_BITS'($urandom_range(0, 4000)) - 16'sd2000, 7'd64);
    run_random_rows(100);
    drain_reports();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_pairs();
    test_crossing_limit();
    test_random_traffic();
    $display("Sent %0d samples, checked %0d reports, %0d register writes", samples_sent,
             reports_checked, reg_writes);
    $display("Covered touches, both crossing directions, count limits and extreme levels");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lci_pkg.sv
rtl/lci_front.sv
rtl/lci_queue.sv
rtl/lci_back.sv
rtl/level_crossing_interpolator_unit.sv
tb/tb.sv
